// ===== hw/rtl/psd_pkg.sv =====
// psd_pkg: shared constants for the point to segment distance pipeline.
// No dependencies; used by psd_step, point_segment_distance_top and psd_checker.
`default_nettype none

package psd_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int LIMIT_BITS     = 8;
    localparam int DIST_BITS      = 17;
    localparam int RULE_BITS      = 2;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd2;
    localparam logic [DIST_BITS-1:0]  DIST_MAX    = 17'd131071;

    localparam logic [RULE_BITS-1:0] RULE_PERP = 2'd0;
    localparam logic [RULE_BITS-1:0] RULE_NEAR = 2'd1;
    localparam logic [RULE_BITS-1:0] RULE_VERT = 2'd2;
    localparam logic [RULE_BITS-1:0] RULE_HORZ = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/psd_step.sv =====
// psd_step: one registered step of the two digit recurrences, one result bit each.
// Depends on psd_pkg.
`default_nettype none

module psd_step
    import psd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int BIT_POS    = 0
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      load,
    input  wire logic                      vld_in,
    input  wire logic [4*COORD_BITS+7:0]   rem_p_in,
    input  wire logic [4*COORD_BITS+7:0]   m_in,
    input  wire logic [COORD_BITS+2:0]     d_in,
    input  wire logic [2*COORD_BITS+1:0]   len2_in,
    input  wire logic [2*COORD_BITS+5:0]   rem_s_in,
    input  wire logic [COORD_BITS+2:0]     r_in,
    input  wire logic [RULE_BITS-1:0]      rule_in,
    input  wire logic [COORD_BITS:0]       alt_in,
    output logic                           vld_out,
    output logic [4*COORD_BITS+7:0]        rem_p_out,
    output logic [4*COORD_BITS+7:0]        m_out,
    output logic [COORD_BITS+2:0]          d_out,
    output logic [2*COORD_BITS+1:0]        len2_out,
    output logic [2*COORD_BITS+5:0]        rem_s_out,
    output logic [COORD_BITS+2:0]          r_out,
    output logic [RULE_BITS-1:0]           rule_out,
    output logic [COORD_BITS:0]            alt_out
);

    localparam int RW = 4*COORD_BITS + 8;
    localparam int SW = 2*COORD_BITS + 6;
    localparam int DW = COORD_BITS + 3;

    logic          vld_reg;
    logic [RW-1:0] rem_p_reg, rem_p_next;
    logic [RW-1:0] m_reg, m_next;
    logic [DW-1:0] d_reg, d_next;
    logic [RW-1:0] inc_p;
    logic [SW-1:0] rem_s_reg, rem_s_next;
    logic [DW-1:0] r_reg, r_next;
    logic [SW-1:0] inc_s;
    logic [2*COORD_BITS+1:0] len2_reg;
    logic [RULE_BITS-1:0]    rule_reg;
    logic [COORD_BITS:0]     alt_reg;

    // (d + 2^b)^2 * len2 - d^2 * len2, with m = d * len2
    always_comb
    begin
        inc_p = (m_in << (BIT_POS + 1)) + (RW'(len2_in) << (2 * BIT_POS));
        rem_p_next = rem_p_in;
        m_next     = m_in;
        d_next     = d_in;
        if (inc_p <= rem_p_in)
        begin
            rem_p_next = rem_p_in - inc_p;
            m_next     = m_in + (RW'(len2_in) << BIT_POS);
            d_next     = d_in | (DW'(1) << BIT_POS);
        end
    end

    always_comb
    begin
        inc_s = (SW'(r_in) << (BIT_POS + 1)) + (SW'(1) << (2 * BIT_POS));
        rem_s_next = rem_s_in;
        r_next     = r_in;
        if (inc_s <= rem_s_in)
        begin
            rem_s_next = rem_s_in - inc_s;
            r_next     = r_in | (DW'(1) << BIT_POS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (load)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_p_reg <= rem_p_next;
            m_reg     <= m_next;
            d_reg     <= d_next;
            rem_s_reg <= rem_s_next;
            r_reg     <= r_next;
            len2_reg  <= len2_in;
            rule_reg  <= rule_in;
            alt_reg   <= alt_in;
        end
    end

    assign vld_out   = vld_reg;
    assign rem_p_out = rem_p_reg;
    assign m_out     = m_reg;
    assign d_out     = d_reg;
    assign len2_out  = len2_reg;
    assign rem_s_out = rem_s_reg;
    assign r_out     = r_reg;
    assign rule_out  = rule_reg;
    assign alt_out   = alt_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/point_segment_distance_top.sv =====
// Point to segment distance: top level, pipeline control and front stages.
// Depends on psd_pkg and psd_step.
//
// Takes one word per cycle unless stalled and returns one word per input word, in order.
// The pipeline has six front stages (differences, products, sums, decision, cross-product
// square in two halves), then one recurrence stage per result bit (COORD_BITS + 3 of them),
// then the output register. Throughput is one word per cycle unless the output stalls.
// Stalls back up only into stages that hold a word, so bubbles are squeezed out.
`default_nettype none

module point_segment_distance_top
    import psd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [LIMIT_BITS-1:0]        cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [COORD_BITS-1:0] point_x,
    input  wire logic signed [COORD_BITS-1:0] point_y,
    input  wire logic signed [COORD_BITS-1:0] end_a_x,
    input  wire logic signed [COORD_BITS-1:0] end_a_y,
    input  wire logic signed [COORD_BITS-1:0] end_b_x,
    input  wire logic signed [COORD_BITS-1:0] end_b_y,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [DIST_BITS-1:0]              distance,
    output logic [RULE_BITS-1:0]              rule_used
);

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int P  = 2*C + 2;
    localparam int Q  = 2*C + 3;
    localparam int U  = 2*C + 2;
    localparam int H  = C + 1;
    localparam int RW = 4*C + 8;
    localparam int SW = 2*C + 6;
    localparam int DW = C + 3;
    localparam int NS = C + 3;
    localparam int XW = (DW > DIST_BITS) ? DW : DIST_BITS;

    logic [LIMIT_BITS-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, vo_reg;
    logic adv1, adv2, adv3, adv4, adv5, adv6, adv_o;
    logic step_vld [0:NS];
    logic step_adv [1:NS+1];

    assign adv_o          = !vo_reg || !out_stall;
    assign step_adv[NS+1] = adv_o;
    assign adv6           = !v6_reg || step_adv[1];
    assign adv5           = !v5_reg || adv6;
    assign adv4           = !v4_reg || adv5;
    assign adv3           = !v3_reg || adv4;
    assign adv2           = !v2_reg || adv3;
    assign adv1           = !v1_reg || adv2;
    assign in_stall       = !adv1;
    assign step_vld[0]    = v6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
            if (adv5)
                v5_reg <= v4_reg;
            if (adv6)
                v6_reg <= v5_reg;
            if (adv_o)
                vo_reg <= step_vld[NS];
        end
    end

    // stage 1: differences
    logic signed [D-1:0] pax_reg, pay_reg, pbx_reg, pby_reg, dx_reg, dy_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            pax_reg <= D'(point_x) - D'(end_a_x);
            pay_reg <= D'(point_y) - D'(end_a_y);
            pbx_reg <= D'(point_x) - D'(end_b_x);
            pby_reg <= D'(point_y) - D'(end_b_y);
            dx_reg  <= D'(end_b_x) - D'(end_a_x);
            dy_reg  <= D'(end_b_y) - D'(end_a_y);
        end
    end

    // stage 2: products and axis classification
    logic signed [P-1:0] sq_pax_reg, sq_pay_reg, sq_pbx_reg, sq_pby_reg;
    logic signed [P-1:0] dot_x_reg, dot_y_reg, sq_dx_reg, sq_dy_reg, cr_a_reg, cr_b_reg;
    logic                general_reg;
    logic [RULE_BITS-1:0] rule2_reg, rule2_next;
    logic [D-1:0]        alt2_reg, alt2_next;
    logic [D-1:0]        abs_pax, abs_pay, abs_dx, abs_dy;
    logic                betw_x, betw_y, vert, horz;

    always_comb
    begin
        abs_pax = pax_reg[D-1] ? D'(-pax_reg) : D'(pax_reg);
        abs_pay = pay_reg[D-1] ? D'(-pay_reg) : D'(pay_reg);
        abs_dx  = dx_reg[D-1]  ? D'(-dx_reg)  : D'(dx_reg);
        abs_dy  = dy_reg[D-1]  ? D'(-dy_reg)  : D'(dy_reg);
        betw_y  = (pay_reg > 0 && pby_reg < 0) || (pay_reg < 0 && pby_reg > 0);
        betw_x  = (pax_reg > 0 && pbx_reg < 0) || (pax_reg < 0 && pbx_reg > 0);
        vert    = abs_dx < D'(limit_reg);
        horz    = abs_dy < D'(limit_reg);
        rule2_next = RULE_NEAR;
        alt2_next  = abs_pax;
        if (vert)
        begin
            if (betw_y)
                rule2_next = RULE_VERT;
        end
        else if (horz)
        begin
            alt2_next = abs_pay;
            if (betw_x)
                rule2_next = RULE_HORZ;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            sq_pax_reg  <= pax_reg * pax_reg;
            sq_pay_reg  <= pay_reg * pay_reg;
            sq_pbx_reg  <= pbx_reg * pbx_reg;
            sq_pby_reg  <= pby_reg * pby_reg;
            dot_x_reg   <= pax_reg * dx_reg;
            dot_y_reg   <= pay_reg * dy_reg;
            sq_dx_reg   <= dx_reg * dx_reg;
            sq_dy_reg   <= dy_reg * dy_reg;
            cr_a_reg    <= pax_reg * dy_reg;
            cr_b_reg    <= dx_reg * pay_reg;
            general_reg <= !vert && !horz;
            rule2_reg   <= rule2_next;
            alt2_reg    <= alt2_next;
        end
    end

    // stage 3: sums
    logic [U-1:0]        da_reg, db_reg, len2_3_reg;
    logic signed [Q-1:0] dot_reg, cr_reg;
    logic                general3_reg;
    logic [RULE_BITS-1:0] rule3_reg;
    logic [D-1:0]        alt3_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            da_reg       <= U'(sq_pax_reg) + U'(sq_pay_reg);
            db_reg       <= U'(sq_pbx_reg) + U'(sq_pby_reg);
            len2_3_reg   <= U'(sq_dx_reg) + U'(sq_dy_reg);
            dot_reg      <= Q'(dot_x_reg) + Q'(dot_y_reg);
            cr_reg       <= Q'(cr_a_reg) - Q'(cr_b_reg);
            general3_reg <= general_reg;
            rule3_reg    <= rule2_reg;
            alt3_reg     <= alt2_reg;
        end
    end

    // stage 4: projection test, nearer endpoint, |cross|
    logic [U-1:0]         nsq4_reg, len2_4_reg, abscr_reg;
    logic [RULE_BITS-1:0] rule4_reg, rule4_next;
    logic [D-1:0]         alt4_reg;

    always_comb
    begin
        rule4_next = rule3_reg;
        if (general3_reg)
        begin
            if (!dot_reg[Q-1] && dot_reg != '0 && dot_reg < $signed({1'b0, len2_3_reg}))
                rule4_next = RULE_PERP;
            else
                rule4_next = RULE_NEAR;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            nsq4_reg   <= (da_reg < db_reg) ? da_reg : db_reg;
            len2_4_reg <= len2_3_reg;
            abscr_reg  <= cr_reg[Q-1] ? U'(-cr_reg) : U'(cr_reg);
            rule4_reg  <= rule4_next;
            alt4_reg   <= alt3_reg;
        end
    end

    // stage 5: partial products of |cross|^2
    logic [2*H-1:0]       hh_reg, hl_reg, ll_reg;
    logic [U-1:0]         nsq5_reg, len2_5_reg;
    logic [RULE_BITS-1:0] rule5_reg;
    logic [D-1:0]         alt5_reg;

    always_ff @(posedge clk)
    begin
        if (adv5)
        begin
            hh_reg     <= abscr_reg[U-1:H] * abscr_reg[U-1:H];
            hl_reg     <= abscr_reg[U-1:H] * abscr_reg[H-1:0];
            ll_reg     <= abscr_reg[H-1:0] * abscr_reg[H-1:0];
            nsq5_reg   <= nsq4_reg;
            len2_5_reg <= len2_4_reg;
            rule5_reg  <= rule4_reg;
            alt5_reg   <= alt4_reg;
        end
    end

    // stage 6: |cross|^2 and recurrence seeds
    logic [RW-1:0]        crsq_reg;
    logic [U-1:0]         nsq6_reg, len2_6_reg;
    logic [RULE_BITS-1:0] rule6_reg;
    logic [D-1:0]         alt6_reg;

    always_ff @(posedge clk)
    begin
        if (adv6)
        begin
            crsq_reg   <= (RW'(hh_reg) << (2*H)) + (RW'(hl_reg) << (H+1)) + RW'(ll_reg);
            nsq6_reg   <= nsq5_reg;
            len2_6_reg <= len2_5_reg;
            rule6_reg  <= rule5_reg;
            alt6_reg   <= alt5_reg;
        end
    end

    // recurrence chain, most significant bit first
    logic [RW-1:0]        rp   [0:NS];
    logic [RW-1:0]        mm   [0:NS];
    logic [DW-1:0]        dd   [0:NS];
    logic [U-1:0]         ll2  [0:NS];
    logic [SW-1:0]        rs   [0:NS];
    logic [DW-1:0]        rr   [0:NS];
    logic [RULE_BITS-1:0] rl   [0:NS];
    logic [D-1:0]         al   [0:NS];

    assign rp[0]  = crsq_reg;
    assign mm[0]  = '0;
    assign dd[0]  = '0;
    assign ll2[0] = len2_6_reg;
    assign rs[0]  = SW'(nsq6_reg);
    assign rr[0]  = '0;
    assign rl[0]  = rule6_reg;
    assign al[0]  = alt6_reg;

    for (genvar k = 1; k <= NS; k++)
    begin : g_step
        assign step_adv[k] = !step_vld[k] || step_adv[k+1];

        psd_step #(
            .COORD_BITS (COORD_BITS),
            .BIT_POS    (NS - k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (step_adv[k]),
            .vld_in    (step_vld[k-1]),
            .rem_p_in  (rp[k-1]),
            .m_in      (mm[k-1]),
            .d_in      (dd[k-1]),
            .len2_in   (ll2[k-1]),
            .rem_s_in  (rs[k-1]),
            .r_in      (rr[k-1]),
            .rule_in   (rl[k-1]),
            .alt_in    (al[k-1]),
            .vld_out   (step_vld[k]),
            .rem_p_out (rp[k]),
            .m_out     (mm[k]),
            .d_out     (dd[k]),
            .len2_out  (ll2[k]),
            .rem_s_out (rs[k]),
            .r_out     (rr[k]),
            .rule_out  (rl[k]),
            .alt_out   (al[k])
        );
    end

    // output register with saturation
    logic [DW-1:0]        pick;
    logic [DIST_BITS-1:0] dist_next, dist_reg;
    logic [RULE_BITS-1:0] rule_reg;

    always_comb
    begin
        case (rl[NS])
            RULE_PERP: pick = dd[NS];
            RULE_NEAR: pick = rr[NS];
            default:   pick = DW'(al[NS]);
        endcase
        if (XW'(pick) > XW'(DIST_MAX))
            dist_next = DIST_MAX;
        else
            dist_next = DIST_BITS'(XW'(pick));
    end

    always_ff @(posedge clk)
    begin
        if (adv_o)
        begin
            dist_reg <= dist_next;
            rule_reg <= rl[NS];
        end
    end

    assign out_valid = vo_reg;
    assign distance  = dist_reg;
    assign rule_used = rule_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/psd_checker.sv =====
// psd_checker: port-level assertions for point_segment_distance_top, and its bind.
// Depends on psd_pkg and point_segment_distance_top.
`default_nettype none

module psd_checker
    import psd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         cfg_wr_en,
    input wire logic [LIMIT_BITS-1:0]        cfg_wr_data,
    input wire logic                         in_valid,
    input wire logic                         in_stall,
    input wire logic signed [COORD_BITS-1:0] point_x,
    input wire logic signed [COORD_BITS-1:0] point_y,
    input wire logic signed [COORD_BITS-1:0] end_a_x,
    input wire logic signed [COORD_BITS-1:0] end_a_y,
    input wire logic signed [COORD_BITS-1:0] end_b_x,
    input wire logic signed [COORD_BITS-1:0] end_b_y,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic [DIST_BITS-1:0]         distance,
    input wire logic [RULE_BITS-1:0]         rule_used
);

    localparam logic [DIST_BITS:0] AXIS_MAX = (DIST_BITS+1)'(1) << COORD_BITS;

    // a held result word does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distance) && $stable(rule_used))
        else $error("result word changed while stalled");

    // the input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // axis rules give a single coordinate difference
    a_axis_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rule_used == RULE_VERT || rule_used == RULE_HORZ)
        |-> {1'b0, distance} <= AXIS_MAX)
        else $error("axis distance out of range");

endmodule

bind point_segment_distance_top psd_checker #(.COORD_BITS(COORD_BITS)) u_psd_checker (.*);

`default_nettype wire
